>>> sv/pidi_pkg.sv
// shared types and constants of the integer pid controller
// no dependencies; imported by every module of the block
package pidi_pkg;

  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned GAIN_WIDTH_DEF   = 16;

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned INTEG_W    = 32;
  localparam int unsigned ACC_W      = INTEG_W + 1;
  localparam int unsigned DRIVE_W    = 32;
  localparam int unsigned TERM_W     = 63;
  localparam int unsigned SUM_W      = 64;

  // each product term is held to +-2^61 before the sum
  localparam logic signed [63:0] TERM_LIMIT = 64'sh2000_0000_0000_0000;

  localparam logic signed [31:0] OUT_LIMIT_RESET = -32'sd1;

  typedef enum logic [2:0] {
    REG_KP,
    REG_KI,
    REG_KD,
    REG_INTEG_MIN,
    REG_INTEG_MAX,
    REG_OUT_MIN,
    REG_OUT_MAX
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] integ_min;
    logic signed [31:0] integ_max;
    logic signed [31:0] out_min;
    logic signed [31:0] out_max;
  } limits_t;

endpackage

>>> sv/pidi_regs.sv
// configuration register file with an apb-style access port
// depends on pidi_pkg
module pidi_regs import pidi_pkg::*; #(
  parameter int unsigned GAIN_WIDTH = GAIN_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  output logic [APB_DATA_W-1:0] prdata_o,
  output logic [GAIN_WIDTH-1:0] kp_o,
  output logic [GAIN_WIDTH-1:0] ki_o,
  output logic [GAIN_WIDTH-1:0] kd_o,
  output limits_t               lim_o
);

  logic [GAIN_WIDTH-1:0] kp_q, ki_q, kd_q;
  limits_t               lim_q;
  reg_idx_e              idx;
  logic                  wr_en;

  assign idx   = reg_idx_e'(paddr_i[APB_ADDR_W-1:2]);
  assign wr_en = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q          <= '0;
      ki_q          <= '0;
      kd_q          <= '0;
      lim_q.integ_min <= '0;
      lim_q.integ_max <= '0;
      lim_q.out_min <= OUT_LIMIT_RESET;
      lim_q.out_max <= OUT_LIMIT_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_KP:        kp_q            <= pwdata_i[GAIN_WIDTH-1:0];
        REG_KI:        ki_q            <= pwdata_i[GAIN_WIDTH-1:0];
        REG_KD:        kd_q            <= pwdata_i[GAIN_WIDTH-1:0];
        REG_INTEG_MIN: lim_q.integ_min <= pwdata_i;
        REG_INTEG_MAX: lim_q.integ_max <= pwdata_i;
        REG_OUT_MIN:   lim_q.out_min   <= pwdata_i;
        REG_OUT_MAX:   lim_q.out_max   <= pwdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_KP:        prdata_o = APB_DATA_W'(kp_q);
      REG_KI:        prdata_o = APB_DATA_W'(ki_q);
      REG_KD:        prdata_o = APB_DATA_W'(kd_q);
      REG_INTEG_MIN: prdata_o = lim_q.integ_min;
      REG_INTEG_MAX: prdata_o = lim_q.integ_max;
      REG_OUT_MIN:   prdata_o = lim_q.out_min;
      REG_OUT_MAX:   prdata_o = lim_q.out_max;
      default:       prdata_o = '0;
    endcase
  end

  assign kp_o  = kp_q;
  assign ki_o  = ki_q;
  assign kd_o  = kd_q;
  assign lim_o = lim_q;

endmodule

>>> sv/pidi_integ.sv
// error, derivative difference and clamped integrator stage
// depends on pidi_pkg; holds the controller's feedback state
module pidi_integ import pidi_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic signed [SAMPLE_WIDTH-1:0] meas_i,
  input  logic signed [SAMPLE_WIDTH-1:0] targ_i,
  input  limits_t                        lim_i,
  output logic signed [SAMPLE_WIDTH:0]   err_o,
  output logic signed [SAMPLE_WIDTH+1:0] diff_o,
  output logic signed [INTEG_W-1:0]      integ_o
);

  localparam int unsigned ERR_W  = SAMPLE_WIDTH + 1;
  localparam int unsigned DIFF_W = SAMPLE_WIDTH + 2;

  logic signed [ERR_W-1:0]   err_d, err_q;
  logic signed [DIFF_W-1:0]  diff_d, diff_q;
  logic signed [ACC_W-1:0]   sum;
  logic signed [INTEG_W-1:0] integ_d, integ_q;

  always_comb begin
    err_d  = ERR_W'(meas_i) - ERR_W'(targ_i);
    // err_q still holds the previous item's error
    diff_d = DIFF_W'(err_d) - DIFF_W'(err_q);
    sum    = ACC_W'(integ_q) + ACC_W'(err_d);
    // upper bound wins when the clamp range is inverted
    if (sum > ACC_W'(lim_i.integ_max)) begin
      integ_d = lim_i.integ_max;
    end else if (sum < ACC_W'(lim_i.integ_min)) begin
      integ_d = lim_i.integ_min;
    end else begin
      integ_d = sum[INTEG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q   <= '0;
      integ_q <= '0;
    end else if (en_i) begin
      err_q   <= err_d;
      integ_q <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_q <= diff_d;
    end
  end

  assign err_o   = err_q;
  assign diff_o  = diff_q;
  assign integ_o = integ_q;

endmodule

>>> sv/pidi_gain_mul.sv
// registered gain multiplier with symmetric term limit
// depends on pidi_pkg
module pidi_gain_mul import pidi_pkg::*; #(
  parameter int unsigned GAIN_W = GAIN_WIDTH_DEF,
  parameter int unsigned X_W    = INTEG_W
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [GAIN_W-1:0]        gain_i,
  input  logic signed [X_W-1:0]    x_i,
  output logic signed [TERM_W-1:0] term_o
);

  localparam int unsigned PROD_W = GAIN_W + 1 + X_W;
  localparam int unsigned EXT_W  = (PROD_W > 64) ? PROD_W : 64;
  localparam logic signed [EXT_W-1:0] LIM_HI = EXT_W'(TERM_LIMIT);
  localparam logic signed [EXT_W-1:0] LIM_LO = -LIM_HI;

  logic signed [PROD_W-1:0] prod;
  logic signed [EXT_W-1:0]  prod_ext;
  logic signed [TERM_W-1:0] term_d, term_q;

  always_comb begin
    prod     = $signed({1'b0, gain_i}) * x_i;
    prod_ext = EXT_W'(prod);
    if (prod_ext > LIM_HI) begin
      term_d = TERM_W'(LIM_HI);
    end else if (prod_ext < LIM_LO) begin
      term_d = TERM_W'(LIM_LO);
    end else begin
      term_d = TERM_W'(prod_ext);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      term_q <= term_d;
    end
  end

  assign term_o = term_q;

endmodule

>>> sv/pidi_limit.sv
// term summation and output range clamp or 32-bit saturation, two stages
// depends on pidi_pkg
module pidi_limit import pidi_pkg::*; (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [TERM_W-1:0]  p_term_i,
  input  logic signed [TERM_W-1:0]  i_term_i,
  input  logic signed [TERM_W-1:0]  d_term_i,
  input  limits_t                   lim_i,
  output logic signed [DRIVE_W-1:0] drive_o
);

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32'sh7fff_ffff);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'($signed(32'h8000_0000));

  logic signed [SUM_W-1:0]   sum_d, sum_q;
  logic signed [DRIVE_W-1:0] drive_d, drive_q;

  assign sum_d = SUM_W'(p_term_i) + SUM_W'(i_term_i) + SUM_W'(d_term_i);

  always_comb begin
    if (lim_i.out_min != lim_i.out_max) begin
      // upper bound wins when the range is inverted
      if (sum_q > SUM_W'(lim_i.out_max)) begin
        drive_d = lim_i.out_max;
      end else if (sum_q < SUM_W'(lim_i.out_min)) begin
        drive_d = lim_i.out_min;
      end else begin
        drive_d = sum_q[DRIVE_W-1:0];
      end
    end else if (sum_q > SAT_HI) begin
      drive_d = SAT_HI[DRIVE_W-1:0];
    end else if (sum_q < SAT_LO) begin
      drive_d = SAT_LO[DRIVE_W-1:0];
    end else begin
      drive_d = sum_q[DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q   <= sum_d;
      drive_q <= drive_d;
    end
  end

  assign drive_o = drive_q;

endmodule

>>> sv/pid_controller_integer.sv
// top level of the integer pid controller with integrator clamp
// depends on pidi_pkg, pidi_regs, pidi_integ, pidi_gain_mul, pidi_limit
//
// Each input beat carries a measured and a target sample; each output beat
// carries one drive value, kp*e + ki*I + kd*(e - e_prev), where e is
// measured - target and I is the running error sum clamped to
// [integ_min, integ_max]. When out_min and out_max differ the drive is
// clamped to that range, otherwise it saturates to signed 32 bits. The
// block takes one beat per clock while the output side accepts, so a
// steady stream runs at one item per cycle. The path is five register
// stages: input register, error and integrator update (the only feedback
// loop, a 33-bit add and clamp compare each cycle), three gain
// multipliers, term sum, and output limit. The whole pipe moves together
// and stalls only when the output register holds a beat that is not taken.
// Gains are unsigned and GAIN_WIDTH bits wide; registers sit at byte
// address 4*i in the order kp, ki, kd, integ_min, integ_max, out_min,
// out_max, and should be written only while no beat is in flight.
module pid_controller_integer import pidi_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int unsigned GAIN_WIDTH   = GAIN_WIDTH_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  // configuration port
  input  logic                                       psel,
  input  logic                                       penable,
  input  logic                                       pwrite,
  input  logic [APB_ADDR_W-1:0]                      paddr,
  input  logic [APB_DATA_W-1:0]                      pwdata,
  output logic [APB_DATA_W-1:0]                      prdata,
  output logic                                       pready,
  // sample input
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // measured, target (SAMPLE_WIDTH bits each), zero pad to whole bytes
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
  // drive output
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // drive (32 bits)
  output logic [DRIVE_W-1:0]                         m_axis_tdata
);

  localparam int unsigned ERR_W  = SAMPLE_WIDTH + 1;
  localparam int unsigned DIFF_W = SAMPLE_WIDTH + 2;

  logic [GAIN_WIDTH-1:0] kp, ki, kd;
  limits_t               lim;

  // valid bits of input, integrator, product and sum stages
  logic [3:0] vld_q;
  logic       out_vld_q;
  logic       pipe_en;

  logic signed [SAMPLE_WIDTH-1:0] meas_q, targ_q;
  logic signed [ERR_W-1:0]        err;
  logic signed [DIFF_W-1:0]       diff;
  logic signed [INTEG_W-1:0]      integ;
  logic signed [TERM_W-1:0]       p_term, i_term, d_term;
  logic signed [DRIVE_W-1:0]      drive;

  // the pipe advances unless a finished beat is stuck at the output
  assign pipe_en       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = pipe_en;
  assign pready        = 1'b1;

  pidi_regs #(
    .GAIN_WIDTH(GAIN_WIDTH)
  ) u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .kp_o      (kp),
    .ki_o      (ki),
    .kd_o      (kd),
    .lim_o     (lim)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (pipe_en) begin
      vld_q     <= {vld_q[2:0], s_axis_tvalid};
      out_vld_q <= vld_q[3];
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      meas_q <= s_axis_tdata[SAMPLE_WIDTH-1:0];
      targ_q <= s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
    end
  end

  // feedback state moves only for real items, never for bubbles
  pidi_integ #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_integ (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en && vld_q[0]),
    .meas_i  (meas_q),
    .targ_i  (targ_q),
    .lim_i   (lim),
    .err_o   (err),
    .diff_o  (diff),
    .integ_o (integ)
  );

  pidi_gain_mul #(
    .GAIN_W (GAIN_WIDTH),
    .X_W    (ERR_W)
  ) u_mul_p (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .gain_i (kp),
    .x_i    (err),
    .term_o (p_term)
  );

  pidi_gain_mul #(
    .GAIN_W (GAIN_WIDTH),
    .X_W    (INTEG_W)
  ) u_mul_i (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .gain_i (ki),
    .x_i    (integ),
    .term_o (i_term)
  );

  pidi_gain_mul #(
    .GAIN_W (GAIN_WIDTH),
    .X_W    (DIFF_W)
  ) u_mul_d (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .gain_i (kd),
    .x_i    (diff),
    .term_o (d_term)
  );

  pidi_limit u_limit (
    .clk_i    (clk_i),
    .en_i     (pipe_en),
    .p_term_i (p_term),
    .i_term_i (i_term),
    .d_term_i (d_term),
    .lim_i    (lim),
    .drive_o  (drive)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = drive;

  // a stalled pipe keeps every stage's occupancy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable({vld_q, out_vld_q}))
    else $error("pipe occupancy changed during a stall");

  // a new output beat comes only from a real item in the sum stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(vld_q[3]))
    else $error("output beat without a source item");

  // integrator stays within an ordered clamp range after each update
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(pipe_en && vld_q[0]) && $past(lim.integ_min <= lim.integ_max)) |->
      (integ >= $past(lim.integ_min) && integ <= $past(lim.integ_max)))
    else $error("integrator outside its clamp range");

  // an ordered output range bounds every delivered drive value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && lim.out_min < lim.out_max) |->
      ($signed(m_axis_tdata) >= lim.out_min && $signed(m_axis_tdata) <= lim.out_max))
    else $error("drive outside the output range");

endmodule
